// ===== src/three_term_recurrence_checksum_defines.svh =====
// Assertion macros shared by the checksum block.
`ifndef THREE_TERM_RECURRENCE_CHECKSUM_DEFINES_SVH
`define THREE_TERM_RECURRENCE_CHECKSUM_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define TTRC_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define TTRC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== src/ttrc_pkg.sv =====
`timescale 1ns / 1ps

package ttrc_pkg;

   localparam int BYTE_W   = 8;
   localparam int TERM_W   = 16;
   localparam int SUM_W    = BYTE_W + 1;
   localparam int PROD_W   = SUM_W + TERM_W;

   localparam logic [BYTE_W-1:0] ALPHA_MUL    = 8'd17;
   localparam logic [BYTE_W-1:0] BETA_MUL     = 8'd31;
   localparam logic [TERM_W-1:0] TERM_MOD     = 16'hFFFF;
   localparam logic [BYTE_W-1:0] FIRST_OFFSET = 8'd7;
   localparam logic [TERM_W-1:0] TERM_RESET   = 16'd1;

   // Reduce a product-sized value modulo 65535: 2^16 folds to 1.
   function automatic logic [TERM_W-1:0] mod_term(input logic [PROD_W-1:0] x);
      logic [TERM_W:0] s;
      s = (TERM_W+1)'(x[PROD_W-1:TERM_W]) + (TERM_W+1)'(x[TERM_W-1:0]);
      if (s >= (TERM_W+1)'(TERM_MOD)) begin
         s = s - (TERM_W+1)'(TERM_MOD);
      end
      return s[TERM_W-1:0];
   endfunction

   // Coefficient (pos * k) mod 256.
   function automatic logic [BYTE_W-1:0] coef(input logic [BYTE_W-1:0] pos,
                                              input logic [BYTE_W-1:0] k);
      logic [2*BYTE_W-1:0] p;
      p = (2*BYTE_W)'(pos) * (2*BYTE_W)'(k);
      return p[BYTE_W-1:0];
   endfunction

endpackage

// ===== src/three_term_recurrence_checksum.sv =====
`timescale 1ns / 1ps
// Channel | Dir | tdata                      | tuser | tlast
// req_*   | in  | [7:0] data_byte            | -     | last
// rsp_*   | out | [15:0] checksum            | -     | -
//
// One request per cycle unless a last request stalls; the request carrying
// last is held in the input register and its checksum in the result register.
// The recurrence loop (9x16 and 8x16-bit multiplies, subtract, mod 65535) is
// combinational between the term registers, which sets the one-request-per-cycle rate.
// Reset is synchronous, active high, and restores the term state.
// A last request stalls only while the result register is still held.

`include "three_term_recurrence_checksum_defines.svh"

module three_term_recurrence_checksum (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata    // [15:0] checksum
);

   localparam int BW = ttrc_pkg::BYTE_W;
   localparam int TW = ttrc_pkg::TERM_W;
   localparam int SW = ttrc_pkg::SUM_W;
   localparam int PW = ttrc_pkg::PROD_W;

   // input register
   logic          in_valid_ff, in_valid_in;
   logic [BW-1:0] in_byte_ff;
   logic          in_last_ff;

   // recurrence state
   logic [TW-1:0] older_ff, older_in;
   logic [TW-1:0] newest_ff, newest_in;
   logic [BW-1:0] position_ff, position_in;
   logic          first_ff, first_in;

   // result register
   logic          rsp_valid_ff, rsp_valid_in;
   logic [TW-1:0] rsp_data_ff, rsp_data_in;

   logic          advance;
   logic [BW-1:0] alpha, beta;
   logic [SW-1:0] mult_a;
   logic [PW-1:0] prod_p, prod_q, diff;
   logic          negative;
   logic [TW-1:0] red, term;

   // Hold a last request while the previous checksum still waits.
   assign advance    = in_valid_ff && !(in_last_ff && rsp_valid_ff && !rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign in_valid_in = req_tready ? req_tvalid : in_valid_ff;

   always_comb begin
      alpha    = ttrc_pkg::coef(position_ff, ttrc_pkg::ALPHA_MUL);
      beta     = ttrc_pkg::coef(position_ff, ttrc_pkg::BETA_MUL);
      mult_a   = SW'(in_byte_ff) + SW'(alpha);
      prod_p   = PW'(mult_a) * PW'(newest_ff);
      prod_q   = PW'(beta) * PW'(older_ff);
      negative = prod_p < prod_q;
      diff     = negative ? (prod_q - prod_p) : (prod_p - prod_q);
      red      = ttrc_pkg::mod_term(diff);
      // A negative difference -d wraps to (1 - d) mod 65535.
      if (!negative) begin
         term = red;
      end else if (red <= TW'(1)) begin
         term = TW'(1) - red;
      end else begin
         term = TW'((TW+1)'(1) << TW) - red;
      end
   end

   always_comb begin
      older_in    = older_ff;
      newest_in   = newest_ff;
      position_in = position_ff;
      first_in    = first_ff;
      rsp_data_in = rsp_data_ff;
      if (advance) begin
         if (first_ff) begin
            older_in    = ttrc_pkg::TERM_RESET;
            newest_in   = TW'(in_byte_ff) + TW'(ttrc_pkg::FIRST_OFFSET);
            position_in = BW'(1);
            first_in    = 1'b0;
         end else begin
            older_in    = newest_ff;
            newest_in   = term;
            position_in = position_ff + BW'(1);
         end
         if (in_last_ff) begin
            // Emit the newest term and drop back to the reset state.
            rsp_data_in = newest_in;
            older_in    = ttrc_pkg::TERM_RESET;
            newest_in   = ttrc_pkg::TERM_RESET;
            position_in = '0;
            first_in    = 1'b1;
         end
      end
   end

   always_comb begin
      if (advance && in_last_ff) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         older_ff     <= ttrc_pkg::TERM_RESET;
         newest_ff    <= ttrc_pkg::TERM_RESET;
         position_ff  <= '0;
         first_ff     <= 1'b1;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         older_ff     <= older_in;
         newest_ff    <= newest_in;
         position_ff  <= position_in;
         first_ff     <= first_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   `TTRC_ASSERT_NEXT(a_last_makes_result, clock, reset, advance && in_last_ff, rsp_valid_ff)
   `TTRC_ASSERT_NEXT(a_last_restores_state, clock, reset, advance && in_last_ff,
                     first_ff && older_ff == ttrc_pkg::TERM_RESET
                     && newest_ff == ttrc_pkg::TERM_RESET)
   `TTRC_ASSERT_NEXT(a_stall_holds_input, clock, reset, in_valid_ff && !advance,
                     in_valid_ff && $stable(in_byte_ff) && $stable(in_last_ff))
   `TTRC_ASSERT_NOW(a_term_reduced, clock, reset, in_valid_ff && !first_ff,
                    newest_ff != ttrc_pkg::TERM_MOD && older_ff != ttrc_pkg::TERM_MOD)

endmodule

// ===== dv/three_term_recurrence_checksum_test.sv =====
`timescale 1ns / 1ps

module three_term_recurrence_checksum_test;

   // Cycle budget: ~850 requests with long sender gaps and receiver
   // stalls, plus the long hold-off, taken many times over.
   localparam int CYCLE_LIMIT  = 400000;
   localparam int RANDOM_ITEMS = 200;
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 10;

   // Track the recurrence per request and hold the checksums still owed.
   class checksum_tracker;
      logic [ttrc_pkg::TERM_W-1:0] older_term;
      logic [ttrc_pkg::TERM_W-1:0] newest_term;
      logic [ttrc_pkg::BYTE_W-1:0] position;
      bit                          starting;
      logic [ttrc_pkg::TERM_W-1:0] owed_checksums[$];
      int unsigned                 mismatches;

      function new();
         restart();
         mismatches = 0;
      endfunction

      function void restart();
         older_term  = ttrc_pkg::TERM_RESET;
         newest_term = ttrc_pkg::TERM_RESET;
         position    = '0;
         starting    = 1'b1;
      endfunction

      // Advance the terms by one accepted request; queue a checksum on last.
      function void absorb_byte(input logic [ttrc_pkg::BYTE_W-1:0] data_byte,
                                input bit last);
         logic [ttrc_pkg::BYTE_W-1:0] alpha;
         logic [ttrc_pkg::BYTE_W-1:0] beta;
         longint unsigned             diff;
         logic [ttrc_pkg::TERM_W-1:0] term;
         if (starting) begin
            older_term  = ttrc_pkg::TERM_RESET;
            newest_term = ttrc_pkg::TERM_W'(data_byte)
                        + ttrc_pkg::TERM_W'(ttrc_pkg::FIRST_OFFSET);
            position    = 8'd1;
            starting    = 1'b0;
         end else begin
            alpha = position * ttrc_pkg::ALPHA_MUL;
            beta  = position * ttrc_pkg::BETA_MUL;
            // Wrap at 2^64 as unsigned 64-bit math does, then reduce.
            diff = (64'(data_byte) + 64'(alpha)) * 64'(newest_term)
                 - 64'(beta) * 64'(older_term);
            term = ttrc_pkg::TERM_W'(diff % 64'(ttrc_pkg::TERM_MOD));
            older_term  = newest_term;
            newest_term = term;
            position    = position + 8'd1;
         end
         if (last) begin
            owed_checksums.push_back(newest_term);
            restart();
         end
      endfunction

      function void compare_checksum(input logic [ttrc_pkg::TERM_W-1:0] actual);
         logic [ttrc_pkg::TERM_W-1:0] owed;
         if (owed_checksums.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected checksum %0d with none owed", actual);
            return;
         end
         owed = owed_checksums.pop_front();
         if (actual !== owed) begin
            mismatches++;
            if (mismatches <= 10)
               $display("checksum mismatch: expected %0d, got %0d", owed, actual);
         end
      endfunction
   endclass

   logic                        clock      = 1'b0;
   logic                        reset      = 1'b1;
   logic                        req_tvalid = 1'b0;
   logic                        req_tready;
   logic [ttrc_pkg::BYTE_W-1:0] req_tdata  = '0;   // [7:0] data_byte
   logic                        req_tlast  = 1'b0;
   logic                        rsp_tvalid;
   logic                        rsp_tready = 1'b0;
   logic [ttrc_pkg::TERM_W-1:0] rsp_tdata;         // [15:0] checksum

   checksum_tracker tracker = new();

   // Percent of cycles in which the sender idles and the receiver stalls.
   int unsigned sender_idle_pct   = 0;
   int unsigned receiver_stall_pct = 0;
   // Bump to ask the receiver process for one long hold-off.
   int unsigned hold_requests     = 0;
   int unsigned accepted_requests = 0;
   int unsigned cycle_count       = 0;

   three_term_recurrence_checksum dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #10 clock = ~clock;

   // Abort a hung run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("DONE: errors detected");
         $finish;
      end
   end

   // Drive rsp_tready: a long hold-off when asked, else random stalls.
   int unsigned hold_left = 0;
   int unsigned hold_seen = 0;
   always @(negedge clock) begin
      if (hold_seen != hold_requests) begin
         hold_seen = hold_requests;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   // Check every checksum handed over, sampled at the edge that moves it.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         tracker.compare_checksum(rsp_tdata);
   end

   // Offer one request, idling at random first; hold it until accepted.
   task automatic send_request(input logic [ttrc_pkg::BYTE_W-1:0] data_byte,
                               input bit last);
      @(negedge clock);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= data_byte;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      tracker.absorb_byte(data_byte, last);
      accepted_requests++;
   endtask

   task automatic send_message(input int unsigned length);
      for (int unsigned i = 0; i < length; i++)
         send_request(ttrc_pkg::BYTE_W'($urandom), i == length - 1);
   endtask

   // Mostly short messages, some medium ones.
   task automatic send_random_messages(input int unsigned quota);
      int unsigned stop_at;
      int unsigned pick;
      stop_at = accepted_requests + quota;
      while (accepted_requests < stop_at) begin
         pick = $urandom_range(99);
         if (pick < 30)
            send_message(1);
         else if (pick < 85)
            send_message($urandom_range(10, 2));
         else
            send_message($urandom_range(40, 11));
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Single-byte messages at the byte extremes and one mid value.
      send_request(8'h00, 1'b1);
      send_request(8'hFF, 1'b1);
      send_request(8'h5A, 1'b1);
      // Short messages of all-ones and all-zeros bytes.
      send_request(8'hFF, 1'b0);
      send_request(8'hFF, 1'b1);
      send_request(8'h00, 1'b0);
      send_request(8'h00, 1'b0);
      send_request(8'h00, 1'b1);
      // Alternating extremes across several positions.
      for (int i = 0; i < 8; i++)
         send_request(i[0] ? 8'h00 : 8'hFF, i == 7);
      // Mixed bytes, last two back to back as single-byte messages.
      send_request(8'hA5, 1'b0);
      send_request(8'h3C, 1'b0);
      send_request(8'h81, 1'b1);
      send_request(8'h01, 1'b1);
      send_request(8'hFE, 1'b1);

      // Long message: position wraps past 255.
      send_message(300);

      // Fill the block while the receiver holds off.
      hold_requests++;
      for (int i = 0; i < 30; i++)
         send_request(ttrc_pkg::BYTE_W'($urandom), 1'b1);

      send_random_messages(RANDOM_ITEMS / 4);

      sender_idle_pct = 47;
      send_random_messages(RANDOM_ITEMS / 4);

      sender_idle_pct    = 0;
      receiver_stall_pct = 47;
      send_random_messages(RANDOM_ITEMS / 4);

      sender_idle_pct    = 38;
      receiver_stall_pct = 38;
      send_random_messages(RANDOM_ITEMS / 4);
      send_message(270);

      // Drop valid and drain the owed checksums.
      @(negedge clock);
      req_tvalid <= 1'b0;
      req_tlast  <= 1'b0;
      receiver_stall_pct = 0;
      while (tracker.owed_checksums.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (tracker.mismatches == 0 && tracker.owed_checksums.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
